### hdl/hyperloglog_sketch_macros.svh
// ----------------------------------------------------------------------------
// hyperloglog_sketch_macros
// Concurrent assertion helpers; clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HYPERLOGLOG_SKETCH_MACROS_SVH
`define HYPERLOGLOG_SKETCH_MACROS_SVH

`ifndef ASSERT_OFF

`define HLL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define HLL_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define HLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HLL_ASSERT_ALWAYS(lbl, expr, msg)
`define HLL_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HLL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/hll_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hll_pkg
// Shared types and constants of the HyperLogLog sketch.
// ----------------------------------------------------------------------------
package hll_pkg;

  localparam int MAX_INDEX_BITS_DEF = 10;
  localparam int MIN_INDEX_BITS     = 4;
  localparam int CFG_W              = 4;
  localparam int RANK_W             = 5;
  localparam int HASH_W             = 32;
  localparam int SUM_W              = 43;
  localparam int CNT_W              = 11;

  localparam logic [CFG_W-1:0]  INDEX_BITS_RESET = CFG_W'(10);
  localparam logic [HASH_W-1:0] FNV_BASIS        = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME        = 32'd16777619;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0] harmonic_sum;
    logic [CNT_W-1:0] zero_count;
  } out_t;

endpackage
`default_nettype wire

### hdl/hll_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hll_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hll_ram #(
  parameter int WIDTH = hll_pkg::RANK_W,
  parameter int DEPTH = 1 << hll_pkg::MAX_INDEX_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hdl/hyperloglog_sketch.sv
// ----------------------------------------------------------------------------
// hyperloglog_sketch
// Bytes without the last flag: accepted back to back while idle.
// Last byte: index, then one leading-zero step per bit, then update.
// Query: walks 2^b rank store entries, b the saturated index width, one read
// per cycle; the result is held while the previous beat waits for out_ready.
// Reset: synchronous rst_n, then a clearing pass over every rank store entry.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hyperloglog_sketch_macros.svh"
module hyperloglog_sketch #(
  parameter int MAX_INDEX_BITS = hll_pkg::MAX_INDEX_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire hll_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output hll_pkg::out_t                   out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [hll_pkg::CFG_W-1:0]  cfg_data
);

  localparam int AW    = MAX_INDEX_BITS;
  localparam int WW    = MAX_INDEX_BITS + 1;
  localparam int DEPTH = 1 << MAX_INDEX_BITS;
  localparam int HW    = hll_pkg::HASH_W;
  localparam int RW    = hll_pkg::RANK_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_IDX   = 5'b00100,
    ST_LZC   = 5'b01000,
    ST_WALK  = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [hll_pkg::CFG_W-1:0]    index_bits_r, index_bits_nxt;
  logic [HW-1:0]                hash_r, hash_nxt;
  logic [HW-1:0]                rest_r, rest_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [RW-1:0]                lz_r, lz_nxt;
  logic [WW-1:0]                walk_r, walk_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [hll_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [hll_pkg::CNT_W-1:0]    zeros_r, zeros_nxt;
  logic [AW-1:0]                clr_r, clr_nxt;
  logic                         out_valid_r, out_valid_nxt;
  hll_pkg::out_t                out_data_r, out_data_nxt;

  logic [4:0]                   eff_b;
  logic [WW-1:0]                count;
  logic [RW-1:0]                lz_lim;
  logic [RW-1:0]                rank;
  logic [HW-1:0]                prod;
  logic [HW-1:0]                idx_shift;
  logic                         issue;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [RW-1:0]                ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [RW-1:0]                ram_rdata;

  hll_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_rank_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (5'(index_bits_r) < 5'(hll_pkg::MIN_INDEX_BITS)) begin
      eff_b = 5'(hll_pkg::MIN_INDEX_BITS);
    end else if (5'(index_bits_r) > 5'(MAX_INDEX_BITS)) begin
      eff_b = 5'(MAX_INDEX_BITS);
    end else begin
      eff_b = 5'(index_bits_r);
    end
  end

  assign count     = WW'(1) << eff_b;
  assign lz_lim    = RW'(6'd32 - 6'(eff_b));
  assign rank      = lz_r + RW'(1);
  assign prod      = HW'((hash_r ^ HW'(in_data.data_byte)) * hll_pkg::FNV_PRIME);
  assign idx_shift = rest_r >> (6'd32 - 6'(eff_b));
  assign issue     = (walk_r != count);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    index_bits_nxt = index_bits_r;
    hash_nxt       = hash_r;
    rest_nxt       = rest_r;
    idx_nxt        = idx_r;
    lz_nxt         = lz_r;
    walk_nxt       = walk_r;
    rd_vld_nxt     = 1'b0;
    sum_nxt        = sum_r;
    zeros_nxt      = zeros_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = rank;
    ram_re         = 1'b0;
    ram_raddr      = walk_r[AW-1:0];

    if (cfg_valid && cfg_ready) begin
      index_bits_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == hll_pkg::REQ_QUERY) begin
            walk_nxt  = '0;
            sum_nxt   = '0;
            zeros_nxt = '0;
            state_nxt = ST_WALK;
          end else if (in_data.last_byte) begin
            rest_nxt  = prod;
            hash_nxt  = hll_pkg::FNV_BASIS;
            state_nxt = ST_IDX;
          end else begin
            hash_nxt = prod;
          end
        end
      end
      ST_IDX: begin
        ram_re    = 1'b1;
        ram_raddr = idx_shift[AW-1:0];
        idx_nxt   = idx_shift[AW-1:0];
        rest_nxt  = rest_r << eff_b;
        lz_nxt    = '0;
        state_nxt = ST_LZC;
      end
      ST_LZC: begin
        if (!rest_r[HW-1] && (lz_r != lz_lim)) begin
          rest_nxt = rest_r << 1;
          lz_nxt   = lz_r + RW'(1);
        end else begin
          ram_we    = (rank > ram_rdata);
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (issue) begin
          ram_re   = 1'b1;
          walk_nxt = walk_r + WW'(1);
        end
        rd_vld_nxt = issue;
        if (rd_vld_r) begin
          sum_nxt   = sum_r + (hll_pkg::SUM_W'(1) << (6'd32 - 6'(ram_rdata)));
          zeros_nxt = zeros_r + hll_pkg::CNT_W'(ram_rdata == '0);
        end
        if (!issue && !rd_vld_r && (!out_valid_r || out_ready)) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.harmonic_sum = sum_r;
          out_data_nxt.zero_count   = zeros_r;
          walk_nxt                  = '0;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      index_bits_r <= hll_pkg::INDEX_BITS_RESET;
      hash_r       <= hll_pkg::FNV_BASIS;
      walk_r       <= '0;
      rd_vld_r     <= 1'b0;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      index_bits_r <= index_bits_nxt;
      hash_r       <= hash_nxt;
      walk_r       <= walk_nxt;
      rd_vld_r     <= rd_vld_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r     <= rest_nxt;
    idx_r      <= idx_nxt;
    lz_r       <= lz_nxt;
    sum_r      <= sum_nxt;
    zeros_r    <= zeros_nxt;
    out_data_r <= out_data_nxt;
  end

  `HLL_ASSERT_IMPLY(a_ram_write_state, ram_we,
                    (state_r == ST_CLEAR || state_r == ST_LZC),
                    "rank store written outside clear or update")
  `HLL_ASSERT_NEXT(a_last_byte_restart,
                   (in_valid && in_ready && (in_data.req_type == hll_pkg::REQ_BYTE) &&
                    in_data.last_byte),
                   (state_r == ST_IDX && hash_r == hll_pkg::FNV_BASIS),
                   "hash not restarted after last byte")
  `HLL_ASSERT_IMPLY(a_lz_bound, (state_r == ST_LZC), (lz_r <= lz_lim),
                    "leading-zero count past rank limit")
  `HLL_ASSERT_IMPLY(a_out_from_walk, $rose(out_valid_r), ($past(state_r) == ST_WALK),
                    "result beat raised outside a walk")

endmodule
`default_nettype wire

### dv/hyperloglog_sketch_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyperloglog_sketch_test
// Drives byte and query beats into the sketch and checks every estimate
// against an in-bench model of the FNV-1a hash, rank update and register walk.
// Covers empty sketches, byte extremes, queries inside an element, index
// width saturation, width changes mid-element and random element traffic
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module hyperloglog_sketch_test;

  localparam int          STORE_DEPTH = 1 << hll_pkg::MAX_INDEX_BITS_DEF;
  localparam int          WALK_SLACK  = 48;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  hll_pkg::in_t              in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  hll_pkg::out_t             out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [hll_pkg::CFG_W-1:0] cfg_data  = '0;

  // sketch model state
  logic [hll_pkg::CFG_W-1:0]  sk_index_bits;
  logic [hll_pkg::HASH_W-1:0] sk_hash;
  logic [hll_pkg::RANK_W-1:0] sk_rank [STORE_DEPTH];
  hll_pkg::out_t              expected_estimates [$];

  bit            idle_on         = 1'b1;
  int unsigned   beats_sent      = 0;
  int unsigned   query_count     = 0;
  int unsigned   results_checked = 0;
  int unsigned   cfg_writes      = 0;
  int unsigned   mismatch_count  = 0;
  int unsigned   cycle_count     = 0;
  int unsigned   ready_hold      = 0;
  hll_pkg::out_t want;

  hyperloglog_sketch i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d estimates pending", cycle_count,
               expected_estimates.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 7);
      out_ready  = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_estimates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected estimate beat: sum %0d zeros %0d",
                   out_data.harmonic_sum, out_data.zero_count);
      end else begin
        want = expected_estimates.pop_front();
        results_checked++;
        if (out_data.harmonic_sum !== want.harmonic_sum ||
            out_data.zero_count !== want.zero_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Estimate %0d mismatch: sum exp %0d got %0d, zeros exp %0d got %0d",
                     results_checked, want.harmonic_sum, out_data.harmonic_sum,
                     want.zero_count, out_data.zero_count);
        end
      end
    end
  end

  function automatic int unsigned leading_zeros(logic [hll_pkg::HASH_W-1:0] v);
    int unsigned n;
    n = 0;
    while (n < hll_pkg::HASH_W && v[hll_pkg::HASH_W-1] == 1'b0) begin
      v = v << 1;
      n++;
    end
    return n;
  endfunction

  function automatic int unsigned width_in_force();
    int unsigned b;
    b = 32'(sk_index_bits);
    if (b < hll_pkg::MIN_INDEX_BITS) b = hll_pkg::MIN_INDEX_BITS;
    if (b > hll_pkg::MAX_INDEX_BITS_DEF) b = hll_pkg::MAX_INDEX_BITS_DEF;
    return b;
  endfunction

  task automatic fold_beat(hll_pkg::in_t beat);
    int unsigned                            b;
    logic [hll_pkg::HASH_W-1:0]             rest;
    logic [hll_pkg::MAX_INDEX_BITS_DEF-1:0] slot;
    int unsigned                            rank;
    logic [63:0]                            sum;
    int unsigned                            zeros;
    hll_pkg::out_t                          est;
    b = width_in_force();
    if (beat.req_type == hll_pkg::REQ_BYTE) begin
      sk_hash = (sk_hash ^ {24'd0, beat.data_byte}) * hll_pkg::FNV_PRIME;
      if (beat.last_byte) begin
        slot = hll_pkg::MAX_INDEX_BITS_DEF'(sk_hash >> (hll_pkg::HASH_W - b));
        rest = sk_hash << b;
        rank = (rest != '0) ? leading_zeros(rest) + 1 : hll_pkg::HASH_W + 1 - b;
        if (rank > sk_rank[slot]) sk_rank[slot] = hll_pkg::RANK_W'(rank);
        sk_hash = hll_pkg::FNV_BASIS;
      end
    end else begin
      sum   = '0;
      zeros = 0;
      for (int unsigned i = 0; i < (1 << b); i++) begin
        if (sk_rank[i] == '0) zeros++;
        sum += 64'd1 << (32 - sk_rank[i]);
      end
      est.harmonic_sum = hll_pkg::SUM_W'(sum);
      est.zero_count   = hll_pkg::CNT_W'(zeros);
      expected_estimates = {expected_estimates, est};
      query_count++;
    end
  endtask

  function automatic hll_pkg::in_t byte_beat(logic [7:0] data, logic last);
    hll_pkg::in_t beat;
    beat.req_type  = hll_pkg::REQ_BYTE;
    beat.data_byte = data;
    beat.last_byte = last;
    return beat;
  endfunction

  function automatic hll_pkg::in_t query_beat();
    hll_pkg::in_t beat;
    beat.req_type  = hll_pkg::REQ_QUERY;
    beat.data_byte = 8'($urandom);
    beat.last_byte = 1'($urandom);
    return beat;
  endfunction

  task automatic send_beat(hll_pkg::in_t beat);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = beat;
    do @(posedge clk); while (!in_ready);
    fold_beat(beat);
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_estimates.size() != 0) @(posedge clk);
    repeat (WALK_SLACK) @(posedge clk);
  endtask

  task automatic write_index_bits(logic [hll_pkg::CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    sk_index_bits = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_element(int unsigned len, bit noisy);
    for (int unsigned i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_beat(query_beat());
      send_beat(byte_beat(8'($urandom), i == len - 1));
    end
  endtask

  task automatic run_random(int unsigned n_beats);
    int unsigned start;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      if ($urandom_range(0, 9) < 7) send_element($urandom_range(1, 6), 1'b1);
      else send_beat(query_beat());
    end
  endtask

  task automatic test_empty_sketch();
    send_beat(query_beat());
  endtask

  task automatic test_byte_extremes();
    send_beat(byte_beat(8'h00, 1'b0));
    send_beat(byte_beat(8'hFF, 1'b1));
    send_beat(byte_beat(8'h00, 1'b1));
    send_beat(byte_beat(8'hFF, 1'b1));
    send_beat(byte_beat(8'h80, 1'b0));
    send_beat(byte_beat(8'h01, 1'b1));
    send_beat(query_beat());
  endtask

  task automatic test_query_inside_element();
    send_beat(byte_beat(8'h5A, 1'b0));
    send_beat(query_beat());
    send_beat(byte_beat(8'hA5, 1'b0));
    send_beat(query_beat());
    send_beat(byte_beat(8'h3C, 1'b1));
    send_beat(query_beat());
  endtask

  task automatic test_width_saturation();
    write_index_bits(4'd0);
    send_beat(byte_beat(8'h42, 1'b0));
    send_beat(byte_beat(8'h24, 1'b1));
    send_beat(query_beat());
    write_index_bits(4'd15);
    send_beat(query_beat());
    write_index_bits(4'd3);
    send_beat(query_beat());
    write_index_bits(4'd11);
    send_beat(query_beat());
  endtask

  task automatic test_width_change_mid_element();
    write_index_bits(4'd4);
    send_beat(byte_beat(8'h11, 1'b0));
    write_index_bits(4'd9);
    send_beat(byte_beat(8'h22, 1'b1));
    send_beat(query_beat());
    write_index_bits(4'd10);
    send_beat(query_beat());
  endtask

  task automatic test_sender_pause();
    write_index_bits(4'd6);
    send_element(3, 1'b0);
    send_beat(query_beat());
    send_beat(query_beat());
    wait_drained();
    send_element(2, 1'b0);
    send_beat(query_beat());
  endtask

  task automatic test_random_traffic();
    logic [hll_pkg::CFG_W-1:0] widths [9];
    widths = '{4'd4, 4'd10, 4'd6, 4'd0, 4'd8, 4'd15, 4'd5, 4'd2, 4'd12};
    foreach (widths[i]) begin
      write_index_bits(widths[i]);
      run_random(50);
    end
  endtask

  task automatic test_streaming_no_idle();
    idle_on = 1'b0;
    write_index_bits(4'd7);
    run_random(60);
  endtask

  initial begin
    sk_index_bits = hll_pkg::INDEX_BITS_RESET;
    sk_hash       = hll_pkg::FNV_BASIS;
    foreach (sk_rank[i]) sk_rank[i] = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_empty_sketch();
    test_byte_extremes();
    test_query_inside_element();
    test_width_saturation();
    test_width_change_mid_element();
    test_sender_pause();
    test_random_traffic();
    test_streaming_no_idle();
    wait_drained();

    $display("Sent %0d beats, checked %0d of %0d estimates, %0d width writes",
             beats_sent, results_checked, query_count, cfg_writes);
    $display("Widths swept from 0 to 15 with saturation, mid-element changes and stalls");
    if (mismatch_count == 0 && expected_estimates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d estimates missing", mismatch_count,
               expected_estimates.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/hll_pkg.sv
hdl/hll_ram.sv
hdl/hyperloglog_sketch.sv
dv/hyperloglog_sketch_test.sv
